FILE: sv/nnpp_pkg.sv
// Shared constants, types and helper functions for the pair potential block.
package nnpp_pkg;

  localparam int MAX_NODES    = 16;
  localparam int MAX_LAYERS   = 4;
  localparam int NUM_TYPES    = 4;
  localparam int WEIGHT_WORDS = 2048;

  localparam int BLOCK_WORDS = MAX_NODES * MAX_NODES + MAX_NODES;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = NODE_W + 1;
  localparam int LAYER_W     = $clog2(MAX_LAYERS + 1);
  localparam int WADDR_W     = $clog2(WEIGHT_WORDS);
  localparam int SCR_DEPTH   = MAX_LAYERS * MAX_NODES;
  localparam int SCR_W       = $clog2(SCR_DEPTH);
  localparam int CUT_DEPTH   = NUM_TYPES * NUM_TYPES;
  localparam int CUT_W       = $clog2(CUT_DEPTH);
  localparam int TYPE_W      = 2;
  localparam int Q_W         = 32;
  localparam int RSQ_W       = 64;
  localparam int ROOT_W      = 32;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 136;
  localparam int HLC_W      = 3;
  localparam int NPL_W      = 5;
  localparam int CFG_DATA_W = 5;

  localparam logic signed [Q_W:0]   ONE_Q  = 33'sd16777216;
  localparam logic signed [Q_W-1:0] SIG_LO = -32'sd134217728;
  localparam logic signed [Q_W-1:0] SIG_HI = 32'sd134217728;

  // request kinds on in_tuser
  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_CUTOFF = 2'd1;
  localparam logic [1:0] REQ_EVAL   = 2'd2;

  // configuration register indexes
  localparam logic CFG_LAYERS = 1'b0;
  localparam logic CFG_NODES  = 1'b1;

  typedef struct packed {
    logic                    hit;
    logic signed [Q_W-1:0]   val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t s;
    if (v[63:31] != {33{v[63]}}) begin
      s.hit = 1'b1;
      s.val = v[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      s.hit = 1'b0;
      s.val = v[31:0];
    end
    return s;
  endfunction

  // sigmoid at x = -8, -7.5, .., 8 in Q8.24
  function automatic logic [23:0] sig_tab(input logic [5:0] i);
    logic [23:0] t;
    case (i)
      6'd0:  t = 24'd5626;
      6'd1:  t = 24'd9274;
      6'd2:  t = 24'd15285;
      6'd3:  t = 24'd25186;
      6'd4:  t = 24'd41484;
      6'd5:  t = 24'd68286;
      6'd6:  t = 24'd112287;
      6'd7:  t = 24'd184330;
      6'd8:  t = 24'd301759;
      6'd9:  t = 24'd491778;
      6'd10: t = 24'd795674;
      6'd11: t = 24'd1272689;
      6'd12: t = 24'd1999893;
      6'd13: t = 24'd3060592;
      6'd14: t = 24'd4512088;
      6'd15: t = 24'd6334081;
      6'd16: t = 24'd8388608;
      6'd17: t = 24'd10443135;
      6'd18: t = 24'd12265128;
      6'd19: t = 24'd13716624;
      6'd20: t = 24'd14777323;
      6'd21: t = 24'd15504527;
      6'd22: t = 24'd15981542;
      6'd23: t = 24'd16285438;
      6'd24: t = 24'd16475457;
      6'd25: t = 24'd16592886;
      6'd26: t = 24'd16664929;
      6'd27: t = 24'd16708930;
      6'd28: t = 24'd16735732;
      6'd29: t = 24'd16752030;
      6'd30: t = 24'd16761931;
      6'd31: t = 24'd16767942;
      default: t = 24'd16771590;
    endcase
    return t;
  endfunction

endpackage

FILE: sv/nn_pair_potential_force.sv
// Top level: neural-network pair potential with force, shared-multiplier sequencer.
//
// Input words (in_*) carry a request kind in in_tuser: weight write, cutoff
// write or pair evaluation. Writes give no output word.
// An evaluation gives exactly one output word (out_*) holding in_range, the
// three force components, the pair energy and the saturation flag.
// in_tready is high only while the sequencer is idle; one item is worked on
// at a time.
// An evaluation computes r^2, makes the cutoff check and runs the 32-step
// square root; then each neuron issues one multiply-accumulate term per
// cycle, in the forward hidden, backward and output-neuron-and-F passes;
// then, for nonzero r, each force component goes through the bit-serial
// divider. The single 33x33 multiplier is used once per cycle in the
// dot-product loops. An out-of-range pair goes from the cutoff check
// straight to the output word.
// Reset (rst_n low, synchronous) returns to idle with 1 hidden layer and 16
// nodes per layer; the weight memory and cutoff table are not cleared.
// A stalled receiver holds the result word on out_tdata; no new input is
// taken until that word is accepted.
module nn_pair_potential_force import nnpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // write_addr, write_value, type_a, type_b, disp_x, disp_y, disp_z, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // in_range, force_x, force_y, force_z, pair_energy, saturated, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_CMP, S_SQRT, S_DOT, S_POST, S_SIG, S_SIG2,
    S_SDRD, S_SDMUL, S_GMUL, S_GWR, S_FMUL, S_FDST, S_FDIV, S_OUT
  } state_t;

  typedef enum logic [1:0] {SRC_ONE, SRC_R, SRC_ACT, SRC_GRAD} src_t;

  // input fields
  logic [WADDR_W-1:0]    write_addr;
  logic signed [Q_W-1:0] write_value, disp_x, disp_y, disp_z;
  logic [TYPE_W-1:0]     type_a, type_b;

  assign write_addr  = in_tdata[10:0];
  assign write_value = in_tdata[42:11];
  assign type_a      = in_tdata[44:43];
  assign type_b      = in_tdata[46:45];
  assign disp_x      = in_tdata[78:47];
  assign disp_y      = in_tdata[110:79];
  assign disp_z      = in_tdata[142:111];

  // control state
  state_t             state_r, state_nxt;
  logic [HLC_W-1:0]   hlc_r, hlc_nxt;
  logic [NPL_W-1:0]   npl_r, npl_nxt;
  logic [1:0]         cnt_r, cnt_nxt, c_r, c_nxt;
  logic [CNT_W-1:0]   t_r, t_nxt;
  logic               v1_r, v1_nxt, v2_r, v2_nxt, bwd_r, bwd_nxt;
  logic [LAYER_W-1:0] lay_r, lay_nxt;
  logic [NODE_W-1:0]  j_r, j_nxt;

  // datapath
  logic signed [Q_W-1:0] d_r [3];
  logic signed [Q_W-1:0] d_nxt [3];
  logic signed [Q_W-1:0] cut_r, cut_nxt, pre_r, pre_nxt, gacc_r, gacc_nxt;
  logic signed [Q_W-1:0] e_r, e_nxt, f_r, f_nxt;
  logic signed [Q_W-1:0] frc_r [3];
  logic signed [Q_W-1:0] frc_nxt [3];
  logic [RSQ_W-1:0]      rsq_r, rsq_nxt;
  logic [LAYER_W-1:0]    h_r, h_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [ROOT_W-1:0]     r_r, r_nxt;
  logic signed [47:0]    acc_r, acc_nxt;
  src_t                  src1_r, src1_nxt;
  logic                  in_range_r, in_range_nxt, sat_r, sat_nxt;
  logic signed [65:0]    prod_r, prod_nxt;
  logic signed [Q_W-1:0] cut_tab_r [CUT_DEPTH];

  // shared multiplier operands
  logic signed [Q_W:0] mul_a, mul_b, op_dot;

  // memories
  logic [Q_W-1:0]     w_rd, act_rd, grad_rd;
  logic [WADDR_W-1:0] w_raddr;
  logic [SCR_W-1:0]   act_raddr, act_raddr_dot, grad_raddr, act_waddr, grad_waddr;
  logic               w_we, act_we, grad_we, cut_we;
  logic [Q_W-1:0]     act_wdata, grad_wdata;

  // dot-product term issue
  logic [CNT_W-1:0]  tcnt;
  logic              issue;
  logic [NODE_W-1:0] k_f, k_b;
  src_t              src_iss;

  // sigmoid interpolation
  logic [Q_W:0]  sig_u;
  logic [4:0]    sig_idx;
  logic [22:0]   sig_frac;
  logic [23:0]   tab_lo, tab_hi, sig_s;

  logic signed [Q_W-1:0] d_sel;
  sat_t                  sat_post, sat_div;

  logic              sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0] sq_root;
  logic signed [63:0] dv_quot;

  logic [HLC_W-1:0] h_eff;
  logic [NPL_W-1:0] n_eff;

  assign h_eff = (hlc_r == '0) ? HLC_W'(1) :
                 ((hlc_r > HLC_W'(MAX_LAYERS)) ? HLC_W'(MAX_LAYERS) : hlc_r);
  assign n_eff = (npl_r == '0) ? NPL_W'(1) :
                 ((npl_r > NPL_W'(MAX_NODES)) ? NPL_W'(MAX_NODES) : npl_r);

  // term schedule: forward uses bias as term 0 (times 1.0), backward has no bias
  always_comb begin
    if (bwd_r) begin
      tcnt = (lay_r == h_r) ? CNT_W'(1) : n_r;
    end else begin
      tcnt = (lay_r == '0) ? CNT_W'(2) : n_r + CNT_W'(1);
    end
    issue = (t_r < tcnt);
    k_f   = NODE_W'(t_r - CNT_W'(1));
    k_b   = NODE_W'(t_r);
    if (bwd_r) begin
      src_iss = (lay_r == h_r) ? SRC_ONE : SRC_GRAD;
      w_raddr = WADDR_W'(int'(lay_r) * BLOCK_WORDS + int'(j_r) * MAX_NODES + int'(k_b));
    end else if (t_r == '0) begin
      src_iss = SRC_ONE;
      w_raddr = WADDR_W'(int'(lay_r) * BLOCK_WORDS + MAX_NODES * MAX_NODES + int'(j_r));
    end else begin
      src_iss = (lay_r == '0) ? SRC_R : SRC_ACT;
      w_raddr = WADDR_W'(int'(lay_r) * BLOCK_WORDS + int'(k_f) * MAX_NODES + int'(j_r));
    end
    act_raddr_dot = SCR_W'((int'(lay_r) - 1) * MAX_NODES + int'(k_f));
    grad_raddr    = SCR_W'(int'(lay_r) * MAX_NODES + int'(k_b));
  end

  assign act_raddr  = (state_r == S_DOT) ? act_raddr_dot :
                      SCR_W'((int'(lay_r) - 1) * MAX_NODES + int'(j_r));
  assign act_waddr  = SCR_W'(int'(lay_r) * MAX_NODES + int'(j_r));
  assign grad_waddr = SCR_W'((int'(lay_r) - 1) * MAX_NODES + int'(j_r));

  // sigmoid: table entry plus floored linear step
  always_comb begin
    sig_u    = Q_W'(0) + {pre_r[Q_W-1], pre_r} - {SIG_LO[Q_W-1], SIG_LO};
    sig_idx  = sig_u[27:23];
    sig_frac = sig_u[22:0];
    tab_lo   = sig_tab({1'b0, sig_idx});
    tab_hi   = sig_tab(6'({1'b0, sig_idx}) + 6'd1);
    if (pre_r <= SIG_LO) begin
      sig_s = sig_tab(6'd0);
    end else if (pre_r >= SIG_HI) begin
      sig_s = sig_tab(6'd32);
    end else begin
      sig_s = tab_lo + {2'b00, prod_r[44:23]};
    end
  end

  always_comb begin
    case (state_r == S_SQ ? cnt_r : c_r)
      2'd0:    d_sel = d_r[0];
      2'd1:    d_sel = d_r[1];
      default: d_sel = d_r[2];
    endcase
  end

  always_comb begin
    case (src1_r)
      SRC_ONE:  op_dot = ONE_Q;
      SRC_R:    op_dot = {1'b0, r_r};
      SRC_ACT:  op_dot = {act_rd[Q_W-1], act_rd};
      default:  op_dot = {grad_rd[Q_W-1], grad_rd};
    endcase
  end

  // operand selection for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ: begin
        mul_a = {d_sel[Q_W-1], d_sel};
        mul_b = {d_sel[Q_W-1], d_sel};
      end
      S_DOT: begin
        mul_a = op_dot;
        mul_b = {w_rd[Q_W-1], w_rd};
      end
      S_SIG: begin
        mul_a = (Q_W+1)'(tab_hi - tab_lo);
        mul_b = (Q_W+1)'(sig_frac);
      end
      S_SDMUL: begin
        mul_a = {1'b0, act_rd};
        mul_b = ONE_Q - $signed({1'b0, act_rd});
      end
      S_GMUL: begin
        mul_a = {gacc_r[Q_W-1], gacc_r};
        mul_b = prod_r[56:24];
      end
      S_FMUL: begin
        mul_a = {d_sel[Q_W-1], d_sel};
        mul_b = -$signed({f_r[Q_W-1], f_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  assign sat_post = sat32({{16{acc_r[47]}}, acc_r});
  assign sat_div  = sat32(dv_quot);

  assign sq_start = (state_r == S_CMP) && !cut_r[Q_W-1] && (cut_r != '0) &&
                    (rsq_r < {8'b0, cut_r, 24'b0});
  assign dv_start = (state_r == S_FDST);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    hlc_nxt      = hlc_r;
    npl_nxt      = npl_r;
    cnt_nxt      = cnt_r;
    c_nxt        = c_r;
    t_nxt        = t_r;
    v1_nxt       = 1'b0;
    v2_nxt       = 1'b0;
    bwd_nxt      = bwd_r;
    lay_nxt      = lay_r;
    j_nxt        = j_r;
    d_nxt        = d_r;
    cut_nxt      = cut_r;
    pre_nxt      = pre_r;
    gacc_nxt     = gacc_r;
    e_nxt        = e_r;
    f_nxt        = f_r;
    frc_nxt      = frc_r;
    rsq_nxt      = rsq_r;
    h_nxt        = h_r;
    n_nxt        = n_r;
    r_nxt        = r_r;
    acc_nxt      = acc_r;
    src1_nxt     = src1_r;
    in_range_nxt = in_range_r;
    sat_nxt      = sat_r;
    w_we         = 1'b0;
    cut_we       = 1'b0;
    act_we       = 1'b0;
    grad_we      = 1'b0;
    act_wdata    = {8'b0, sig_s};
    grad_wdata   = prod_r[55:24];

    if (cfg_wr_en) begin
      if (cfg_addr == CFG_LAYERS) begin
        hlc_nxt = cfg_wdata[HLC_W-1:0];
      end else begin
        npl_nxt = cfg_wdata;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == REQ_WEIGHT) begin
            w_we = 1'b1;
          end else if (in_tuser == REQ_CUTOFF) begin
            cut_we = (write_addr < WADDR_W'(CUT_DEPTH));
          end else if (in_tuser == REQ_EVAL) begin
            d_nxt[0]  = disp_x;
            d_nxt[1]  = disp_y;
            d_nxt[2]  = disp_z;
            cut_nxt   = cut_tab_r[CUT_W'(int'(type_a) * NUM_TYPES + int'(type_b))];
            rsq_nxt   = '0;
            cnt_nxt   = '0;
            sat_nxt   = 1'b0;
            h_nxt     = h_eff;
            n_nxt     = n_eff;
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        if (cnt_r != 2'd0) begin
          rsq_nxt = rsq_r + prod_r[RSQ_W-1:0];
        end
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sq_start) begin
          in_range_nxt = 1'b1;
          state_nxt    = S_SQRT;
        end else begin
          in_range_nxt = 1'b0;
          frc_nxt[0]   = '0;
          frc_nxt[1]   = '0;
          frc_nxt[2]   = '0;
          e_nxt        = '0;
          state_nxt    = S_OUT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          r_nxt     = sq_root;
          lay_nxt   = '0;
          j_nxt     = '0;
          bwd_nxt   = 1'b0;
          t_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_DOT;
        end
      end
      S_DOT: begin
        v1_nxt   = issue;
        v2_nxt   = v1_r;
        src1_nxt = src_iss;
        if (issue) begin
          t_nxt = t_r + CNT_W'(1);
        end
        if (v2_r) begin
          acc_nxt = acc_r + {{6{prod_r[65]}}, prod_r[65:24]};
        end
        if (!issue && !v1_r && !v2_r) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        sat_nxt = sat_r | sat_post.hit;
        if (!bwd_r && (lay_r != h_r)) begin
          pre_nxt   = sat_post.val;
          state_nxt = S_SIG;
        end else if (!bwd_r) begin
          // output neuron done, start backward pass at the output layer
          e_nxt     = sat_post.val;
          bwd_nxt   = 1'b1;
          lay_nxt   = h_r;
          j_nxt     = '0;
          t_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_DOT;
        end else if (lay_r != '0) begin
          gacc_nxt  = sat_post.val;
          state_nxt = S_SDRD;
        end else begin
          f_nxt     = sat_post.val;
          c_nxt     = '0;
          state_nxt = S_FMUL;
        end
      end
      S_SIG: begin
        state_nxt = S_SIG2;
      end
      S_SIG2, S_GWR: begin
        act_we  = (state_r == S_SIG2);
        grad_we = (state_r == S_GWR);
        if ((CNT_W'(j_r) + CNT_W'(1)) < n_r) begin
          j_nxt = j_r + NODE_W'(1);
        end else begin
          j_nxt   = '0;
          lay_nxt = bwd_r ? lay_r - LAYER_W'(1) : lay_r + LAYER_W'(1);
        end
        t_nxt     = '0;
        acc_nxt   = '0;
        state_nxt = S_DOT;
      end
      S_SDRD: begin
        state_nxt = S_SDMUL;
      end
      S_SDMUL: begin
        state_nxt = S_GMUL;
      end
      S_GMUL: begin
        state_nxt = S_GWR;
      end
      S_FMUL: begin
        if (r_r == '0) begin
          frc_nxt[0] = '0;
          frc_nxt[1] = '0;
          frc_nxt[2] = '0;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_FDST;
        end
      end
      S_FDST: begin
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        if (dv_done) begin
          frc_nxt[c_r] = sat_div.val;
          sat_nxt      = sat_r | sat_div.hit;
          if (c_r == 2'd2) begin
            state_nxt = S_OUT;
          end else begin
            c_nxt     = c_r + 2'd1;
            state_nxt = S_FMUL;
          end
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hlc_r   <= HLC_W'(1);
      npl_r   <= NPL_W'(MAX_NODES);
      cnt_r   <= '0;
      c_r     <= '0;
      t_r     <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      bwd_r   <= 1'b0;
      lay_r   <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      hlc_r   <= hlc_nxt;
      npl_r   <= npl_nxt;
      cnt_r   <= cnt_nxt;
      c_r     <= c_nxt;
      t_r     <= t_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      bwd_r   <= bwd_nxt;
      lay_r   <= lay_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    cut_r      <= cut_nxt;
    pre_r      <= pre_nxt;
    gacc_r     <= gacc_nxt;
    e_r        <= e_nxt;
    f_r        <= f_nxt;
    frc_r      <= frc_nxt;
    rsq_r      <= rsq_nxt;
    h_r        <= h_nxt;
    n_r        <= n_nxt;
    r_r        <= r_nxt;
    acc_r      <= acc_nxt;
    src1_r     <= src1_nxt;
    in_range_r <= in_range_nxt;
    sat_r      <= sat_nxt;
    prod_r     <= prod_nxt;
    if (cut_we) begin
      cut_tab_r[write_addr[CUT_W-1:0]] <= write_value;
    end
  end

  nnpp_ram #(.WIDTH(Q_W), .DEPTH(WEIGHT_WORDS)) u_wmem (
    .clk   (clk),
    .we    (w_we),
    .waddr (write_addr),
    .wdata (write_value),
    .raddr (w_raddr),
    .rdata (w_rd)
  );

  // hidden-layer activations, row per layer
  nnpp_ram #(.WIDTH(Q_W), .DEPTH(SCR_DEPTH)) u_act (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .raddr (act_raddr),
    .rdata (act_rd)
  );

  // back-propagated gradients, row per layer
  nnpp_ram #(.WIDTH(Q_W), .DEPTH(SCR_DEPTH)) u_grad (
    .clk   (clk),
    .we    (grad_we),
    .waddr (grad_waddr),
    .wdata (grad_wdata),
    .raddr (grad_raddr),
    .rdata (grad_rd)
  );

  nnpp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (rsq_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  nnpp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (prod_r[63:0]),
    .den   (r_r),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'b0, sat_r, e_r, frc_r[2], frc_r[1], frc_r[0], in_range_r};

endmodule

FILE: sv/nnpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nnpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/nnpp_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module nnpp_isqrt import nnpp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RSQ_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RSQ_W-1:0] v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt, trial;
  logic             done_r, done_nxt;

  always_comb begin
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    done_nxt = 1'b0;
    trial    = res_r + bit_r;
    if (start) begin
      v_nxt   = radicand;
      res_nxt = '0;
      bit_nxt = {2'b01, {(RSQ_W-2){1'b0}}};
    end else if (bit_r != '0) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt  = bit_r >> 2;
      done_nxt = (bit_r == RSQ_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r  <= '0;
      done_r <= 1'b0;
    end else begin
      bit_r  <= bit_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

FILE: sv/nnpp_div.sv
// Iterative signed divide by an unsigned divisor, one quotient bit per cycle, truncating.
module nnpp_div import nnpp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [ROOT_W-1:0]  den,
  output logic               done,
  output logic signed [63:0] quot
);

  logic [63:0]       mag_r, mag_nxt, q_r, q_nxt;
  logic [ROOT_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [ROOT_W:0]   rem_sh;
  logic              neg_r, neg_nxt, ge;
  logic [6:0]        cnt_r, cnt_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    mag_nxt  = mag_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, mag_r[63]};
    ge       = (rem_sh >= {1'b0, den_r});
    if (start) begin
      neg_nxt = num[63];
      mag_nxt = num[63] ? 64'(-num) : 64'(num);
      den_nxt = den;
      rem_nxt = '0;
      q_nxt   = '0;
      cnt_nxt = 7'd64;
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? ROOT_W'(rem_sh - {1'b0, den_r}) : rem_sh[ROOT_W-1:0];
      q_nxt    = {q_r[62:0], ge};
      mag_nxt  = mag_r << 1;
      cnt_nxt  = cnt_r - 7'd1;
      done_nxt = (cnt_r == 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

FILE: tb/sv/tb_nn_pair_potential_force.sv
// Testbench for the pair potential block: directed table, random phases, scoreboard.
module tb_nn_pair_potential_force;
  import nnpp_pkg::*;

  // request code that the block ignores
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int ONE = 16777216;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int PHASE_ITEMS = 50;

  typedef struct {
    bit                 in_range;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] energy;
    bit                 saturated;
  } pair_result_t;

  typedef struct {
    logic [1:0]         req;
    logic [10:0]        addr;
    logic [31:0]        value;
    logic [1:0]         ta;
    logic [1:0]         tb;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    bit                 typed;     // row expects the all-zero out-of-range word
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = REQ_WEIGHT;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic cfg_addr = CFG_LAYERS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  nn_pair_potential_force uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------
  // Shadow of the block state, kept in step with accepted words
  // ---------------------------------------------------------------
  longint weight_mem [0:WEIGHT_WORDS-1];
  bit     weight_loaded [0:WEIGHT_WORDS-1];
  longint cutoff_mem [0:CUT_DEPTH-1];
  logic [2:0] layers_reg = 3'd1;
  logic [4:0] nodes_reg = 5'd16;
  bit clip_hit;

  longint sig_points [0:32] = '{
    5626, 9274, 15285, 25186, 41484, 68286, 112287, 184330,
    301759, 491778, 795674, 1272689, 1999893, 3060592, 4512088, 6334081,
    8388608,
    10443135, 12265128, 13716624, 14777323, 15504527, 15981542, 16285438,
    16475457, 16592886, 16664929, 16708930, 16735732, 16752030, 16761931,
    16767942, 16771590};

  pair_result_t force_q[$];      // forces/energies still owed by the block
  int mismatches = 0;
  bit quiet = 1'b0;              // no idling on either side
  longint cycles = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      clip_hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip_hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Q8.24 product, floored
  function automatic longint qprod(longint a, longint b);
    return (a * b) >>> 24;
  endfunction

  function automatic longint wgt(int l, int row, int col);
    return weight_mem[l * BLOCK_WORDS + row * MAX_NODES + col];
  endfunction

  function automatic longint bias(int l, int col);
    return weight_mem[l * BLOCK_WORDS + MAX_NODES * MAX_NODES + col];
  endfunction

  // interpolated sigmoid, ends held
  function automatic longint sigmoid_q(longint x);
    longint u, idx, frac;
    if (x <= -64'sd134217728) return sig_points[0];
    if (x >= 64'sd134217728) return sig_points[32];
    u = x + 64'sd134217728;
    idx = u >> 23;
    frac = u & 64'h7FFFFF;
    return sig_points[idx] + (((sig_points[idx + 1] - sig_points[idx]) * frac) >> 23);
  endfunction

  function automatic longint sigmoid_slope(longint x);
    longint s;
    s = sigmoid_q(x);
    return (s * (ONE - s)) >> 24;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int eff_layers();
    if (layers_reg < 1) return 1;
    if (layers_reg > MAX_LAYERS) return MAX_LAYERS;
    return layers_reg;
  endfunction

  function automatic int eff_nodes();
    if (nodes_reg < 1) return 1;
    if (nodes_reg > MAX_NODES) return MAX_NODES;
    return nodes_reg;
  endfunction

  // energy and force for one pair under the current setting
  function automatic pair_result_t pair_force(logic [1:0] ta, logic [1:0] tb,
                                              logic signed [31:0] dx,
                                              logic signed [31:0] dy,
                                              logic signed [31:0] dz);
    pair_result_t res;
    longint d [0:2];
    longint pre [0:(MAX_LAYERS+2)*MAX_NODES-1];
    longint grad [0:(MAX_LAYERS+2)*MAX_NODES-1];
    longint unsigned rsq;
    longint cut, r, e, f, acc;
    int h, n, nxt;
    res = '{default: '0};
    d[0] = dx;
    d[1] = dy;
    d[2] = dz;
    rsq = 0;
    for (int c = 0; c < 3; c++) rsq += longint'(d[c] * d[c]);
    cut = cutoff_mem[ta * NUM_TYPES + tb];
    if (cut <= 0 || rsq >= (longint'(cut) << 24)) return res;
    h = eff_layers();
    n = eff_nodes();
    clip_hit = 1'b0;
    r = longint'(root64(rsq));
    // forward
    for (int j = 0; j < n; j++) pre[MAX_NODES + j] = clip32(bias(0, j) + qprod(r, wgt(0, 0, j)));
    for (int l = 1; l < h; l++)
      for (int j = 0; j < n; j++) begin
        acc = bias(l, j);
        for (int k = 0; k < n; k++)
          acc += qprod(sigmoid_q(pre[l * MAX_NODES + k]), wgt(l, k, j));
        pre[(l + 1) * MAX_NODES + j] = clip32(acc);
      end
    acc = bias(h, 0);
    for (int k = 0; k < n; k++) acc += qprod(sigmoid_q(pre[h * MAX_NODES + k]), wgt(h, k, 0));
    e = clip32(acc);
    // backward from a unit output gradient
    grad[(h + 1) * MAX_NODES] = ONE;
    for (int l = h; l >= 1; l--) begin
      nxt = (l == h) ? 1 : n;
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < nxt; k++) acc += qprod(grad[(l + 1) * MAX_NODES + k], wgt(l, j, k));
        acc = clip32(acc);
        grad[l * MAX_NODES + j] = qprod(acc, sigmoid_slope(pre[l * MAX_NODES + j]));
      end
    end
    acc = 0;
    for (int k = 0; k < n; k++) acc += qprod(grad[MAX_NODES + k], wgt(0, 0, k));
    f = clip32(acc);
    res.in_range = 1'b1;
    res.energy = e[31:0];
    if (r != 0) begin
      res.force_x = clip32((d[0] * (-f)) / r);
      res.force_y = clip32((d[1] * (-f)) / r);
      res.force_z = clip32((d[2] * (-f)) / r);
    end
    res.saturated = clip_hit;
    return res;
  endfunction

  // ---------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------
  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Result side: random stall bursts, scoreboard
  // ---------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= rst_n;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pair_result_t want, got;
    bit bad;
    if (rst_n && out_tvalid && out_tready) begin
      got.in_range  = out_tdata[0];
      got.force_x   = out_tdata[32:1];
      got.force_y   = out_tdata[64:33];
      got.force_z   = out_tdata[96:65];
      got.energy    = out_tdata[128:97];
      got.saturated = out_tdata[129];
      if (force_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word at cycle %0d", cycles);
      end else begin
        want = force_q.pop_front();
        bad = (got.in_range != want.in_range) || (got.force_x != want.force_x) ||
              (got.force_y != want.force_y) || (got.force_z != want.force_z) ||
              (got.energy != want.energy) || (got.saturated != want.saturated);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rng=%0d f=(%0d,%0d,%0d) e=%0d sat=%0d | got rng=%0d f=(%0d,%0d,%0d) e=%0d sat=%0d",
                     want.in_range, want.force_x, want.force_y, want.force_z, want.energy,
                     want.saturated, got.in_range, got.force_x, got.force_y, got.force_z,
                     got.energy, got.saturated);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------
  // Drive one word, wait for the handshake, then fold it into the shadow.
  task automatic send_word(stim_row_t w);
    pair_result_t none;
    none = '{default: '0};
    in_tvalid <= 1'b1;
    in_tuser <= w.req;
    in_tdata <= {1'b0, w.dz, w.dy, w.dx, w.tb, w.ta, w.value, w.addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (w.req)
      REQ_WEIGHT: begin
        weight_mem[w.addr] = longint'(signed'(w.value));
        weight_loaded[w.addr] = 1'b1;
      end
      REQ_CUTOFF: if (w.addr < CUT_DEPTH) cutoff_mem[w.addr] = longint'(signed'(w.value));
      REQ_EVAL: force_q.push_back(w.typed ? none : pair_force(w.ta, w.tb, w.dx, w.dy, w.dz));
      default: ;
    endcase
    // random gap after the word
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // hold off until every owed result is back, then let the sequencer settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (force_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_shape(logic [2:0] layers, logic [4:0] nodes);
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_LAYERS;
    cfg_wdata <= {2'b00, layers};
    @(posedge clk);
    cfg_addr <= CFG_NODES;
    cfg_wdata <= nodes;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    layers_reg = layers;
    nodes_reg = nodes;
  endtask

  function automatic logic [31:0] rand_weight();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
  endfunction

  function automatic logic [31:0] rand_disp();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 8) - 4;
      default: return $urandom_range(0, 2 * ONE) - ONE;
    endcase
  endfunction

  function automatic stim_row_t weight_row(int addr, logic [31:0] v);
    stim_row_t w;
    w = '{default: '0};
    w.req = REQ_WEIGHT;
    w.addr = addr;
    w.value = v;
    return w;
  endfunction

  // write every weight the current shape reads that has not been written yet
  task automatic load_net();
    int h, n, a;
    h = eff_layers();
    n = eff_nodes();
    for (int l = 0; l <= h; l++)
      for (int row = 0; row <= MAX_NODES; row++)
        for (int col = 0; col < n; col++) begin
          a = l * BLOCK_WORDS + row * MAX_NODES + col;
          if ((l == 0 && row != 0 && row != MAX_NODES) || (l == h && col != 0) ||
              (row != MAX_NODES && row >= n && l != 0))
            continue;
          if (!weight_loaded[a]) send_word(weight_row(a, rand_weight()));
        end
  endtask

  task automatic random_items(int count);
    stim_row_t w;
    int pick;
    for (int i = 0; i < count; i++) begin
      w = '{default: '0};
      w.addr = $urandom;
      w.value = $urandom;
      w.ta = $urandom;
      w.tb = $urandom;
      w.dx = rand_disp();
      w.dy = rand_disp();
      w.dz = rand_disp();
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        w.req = REQ_EVAL;
      end else if (pick < 16) begin
        w.req = REQ_WEIGHT;
        w.value = rand_weight();
      end else if (pick < 19) begin
        w.req = REQ_CUTOFF;
        if ($urandom_range(0, 3) != 0) begin
          w.addr = $urandom_range(0, CUT_DEPTH - 1);
          w.value = $urandom_range(ONE / 4, 9 * ONE);
        end
      end else begin
        w.req = REQ_NONE;
      end
      send_word(w);
    end
  endtask

  // Directed table; typed rows expect the all-zero out-of-range word.
  stim_row_t directed [] = '{
    '{REQ_CUTOFF, 11'd0,    32'h0400_0000, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{REQ_CUTOFF, 11'd5,    32'h0000_0000, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{REQ_CUTOFF, 11'd10,   32'hFFFF_FFFF, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{REQ_CUTOFF, 11'd15,   32'h7FFF_FFFF, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{REQ_CUTOFF, 11'd16,   32'h0000_0001, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{REQ_CUTOFF, 11'd2047, 32'h8000_0000, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{REQ_WEIGHT, 11'd0,    32'h0100_0000, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{REQ_WEIGHT, 11'd256,  32'h8000_0000, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{REQ_WEIGHT, 11'd272,  32'h7FFF_FFFF, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{REQ_WEIGHT, 11'd528,  32'h0080_0000, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{REQ_WEIGHT, 11'd2047, 32'hFFFF_FFFF, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{REQ_NONE,   11'h7FF,  32'hFFFF_FFFF, 2'd3, 2'd3, -32'sd1, -32'sd1, -32'sd1, 1'b0},
    // zero distance: energy only
    '{REQ_EVAL,   11'd0,    32'h0,         2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    // saturating network, plain axis displacement
    '{REQ_EVAL,   11'd0,    32'h0,         2'd0, 2'd0, 32'sd16777216, 32'sd0, 32'sd0, 1'b0},
    '{REQ_EVAL,   11'd0,    32'h0,         2'd0, 2'd0, -32'sd1, 32'sd1, -32'sd1, 1'b0},
    // r^2 equal to the cutoff is out of range
    '{REQ_EVAL,   11'd0,    32'h0,         2'd0, 2'd0, 32'sd33554432, 32'sd0, 32'sd0, 1'b1},
    '{REQ_EVAL,   11'd0,    32'h0,         2'd1, 2'd1, 32'sd1, 32'sd0, 32'sd0, 1'b1},
    '{REQ_EVAL,   11'd0,    32'h0,         2'd2, 2'd2, 32'sd1, 32'sd0, 32'sd0, 1'b1},
    '{REQ_EVAL,   11'd0,    32'h0,         2'd3, 2'd3, 32'h8000_0000, 32'h8000_0000,
      32'h8000_0000, 1'b1},
    '{REQ_EVAL,   11'd0,    32'h0,         2'd3, 2'd3, 32'h7FFF_FFFF, 32'sd0, 32'sd0, 1'b1},
    '{REQ_EVAL,   11'd0,    32'h0,         2'd3, 2'd3, 32'sd3, -32'sd5, 32'sd1000, 1'b0},
    '{REQ_EVAL,   11'd0,    32'h0,         2'd0, 2'd0, 32'sd1000000, -32'sd9000000,
      32'sd2000000, 1'b0}
  };

  // raw register settings per phase, clamped values among them
  logic [2:0] phase_layers [0:7] = '{3'd0, 3'd2, 3'd4, 3'd7, 3'd1, 3'd1, 3'd3, 3'd1};
  logic [4:0] phase_nodes  [0:7] = '{5'd0, 5'd3, 5'd2, 5'd2, 5'd16, 5'd31, 5'd4, 5'd5};

  initial begin
    for (int a = 0; a < WEIGHT_WORDS; a++) begin
      weight_mem[a] = 0;
      weight_loaded[a] = 1'b0;
    end
    for (int a = 0; a < CUT_DEPTH; a++) cutoff_mem[a] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_shape(3'd1, 5'd1);
    foreach (directed[i]) send_word(directed[i]);
    drain();

    // fresh cutoffs for every type pair, a few left closed
    for (int a = 0; a < CUT_DEPTH; a++) begin
      stim_row_t w;
      w = '{default: '0};
      w.req = REQ_CUTOFF;
      w.addr = a;
      w.value = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom_range(ONE / 2, 9 * ONE);
      send_word(w);
    end

    for (int p = 0; p < 8; p++) begin
      drain();
      set_shape(phase_layers[p], phase_nodes[p]);
      if (p == 7) quiet = 1'b1;
      load_net();
      random_items(PHASE_ITEMS);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (force_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && force_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: nn_pair_potential_force.f
sv/nnpp_pkg.sv
sv/nnpp_ram.sv
sv/nnpp_isqrt.sv
sv/nnpp_div.sv
sv/nn_pair_potential_force.sv
tb/sv/tb_nn_pair_potential_force.sv
